FILE: src/ptfh_pkg.sv
// Shared types, constants and helper functions of the peak triplet filter and hash block.
package ptfh_pkg;

	// Configuration register indexes
	localparam logic [1:0] REG_MIN_FREQ_DELTA = 2'd0;
	localparam logic [1:0] REG_MAX_FREQ_DELTA = 2'd1;
	localparam logic [1:0] REG_MAX_TIME_DELTA = 2'd2;
	localparam logic [1:0] REG_QUANT_STEP     = 2'd3;

	// Configuration reset values
	localparam logic [15:0] RST_MIN_FREQ_DELTA = 16'd30;
	localparam logic [15:0] RST_MAX_FREQ_DELTA = 16'd300;
	localparam logic [15:0] RST_MAX_TIME_DELTA = 16'd300;
	localparam logic [9:0]  RST_QUANT_STEP     = 10'd10;

	// Reject reason codes
	localparam logic [2:0] RSN_OK        = 3'd0;
	localparam logic [2:0] RSN_DF1_SMALL = 3'd1;
	localparam logic [2:0] RSN_DF1_LARGE = 3'd2;
	localparam logic [2:0] RSN_DT1_LARGE = 3'd3;
	localparam logic [2:0] RSN_DF2_RANGE = 3'd4;
	localparam logic [2:0] RSN_DT2_LARGE = 3'd5;
	localparam logic [2:0] RSN_SIMILAR   = 3'd6;

	// Queue sizes
	localparam int MQ_DEPTH = 4;
	localparam int MQ_AW    = $clog2(MQ_DEPTH);
	localparam int OQ_DEPTH = 8;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);

	// Quotient bits resolved by the time divider, saturation code
	localparam int          QUO_W   = 6;
	localparam logic [5:0]  QUO_SAT = 6'd63;
	localparam logic [5:0]  T_ZERO  = 6'd32;
	localparam logic [5:0]  Q_POS_MAX = 6'd31;
	localparam logic [5:0]  Q_NEG_MAX = 6'd32;

	// Classified item handed from the front to the back
	typedef struct packed {
		logic [2:0]  reason;
		logic [9:0]  fcode1;
		logic [9:0]  fcode2;
		logic [15:0] tmag1;
		logic        tneg1;
		logic [15:0] tmag2;
		logic        tneg2;
		logic [11:0] freq_hi;
		logic [31:0] ptime;
		logic [15:0] pfreq;
		logic [15:0] plevel;
	} work_t;

	// One lane of the quantizing divider
	typedef struct packed {
		logic [15:0]      rem;
		logic [QUO_W-1:0] quo;
		logic             sat;
		logic             neg;
	} div_lane_t;

	// Result item
	typedef struct packed {
		logic        accepted;
		logic [2:0]  reason;
		logic [31:0] hash;
		logic [31:0] ptime;
		logic [15:0] pfreq;
		logic [15:0] plevel;
	} res_t;

	// Filter thresholds seen by the front
	typedef struct packed {
		logic [15:0] fmin;
		logic [15:0] fmax;
		logic [15:0] tmax;
	} limits_t;

	// Start a divider lane: saturation check against step * 64
	function automatic div_lane_t div_start(logic [15:0] mag, logic neg, logic [9:0] st);
		div_lane_t l;
		l.rem = mag;
		l.quo = '0;
		l.neg = neg;
		l.sat = ({1'b0, mag} >= ({7'd0, st} << QUO_W));
		return l;
	endfunction

	// Two restoring division steps, resolving quotient bits top and top-1
	function automatic div_lane_t div_steps(div_lane_t l, logic [9:0] st, int top);
		div_lane_t r;
		logic [15:0] d;
		r = l;
		for (int k = 0; k < 2; k++) begin
			d = 16'({6'd0, st} << (top - k));
			if (r.rem >= d) begin
				r.rem = r.rem - d;
				r.quo[top-k] = 1'b1;
			end
		end
		return r;
	endfunction

	// Saturated, offset time code from a finished divider lane
	function automatic logic [5:0] time_code(div_lane_t l);
		logic [5:0] qm;
		logic [5:0] t;
		qm = l.sat ? QUO_SAT : l.quo;
		if (!l.neg) begin
			t = T_ZERO + ((qm > Q_POS_MAX) ? Q_POS_MAX : qm);
		end else begin
			t = T_ZERO - ((qm > Q_NEG_MAX) ? Q_NEG_MAX : qm);
		end
		return t;
	endfunction

	// Mix a frequency code with a time code
	function automatic logic [9:0] combo(logic [9:0] fcode, logic [5:0] t);
		return fcode ^ {t[1:0], 8'd0} ^ {2'd0, t[5:2], 4'd0};
	endfunction

endpackage

FILE: src/peak_triplet_filter_hash.sv
// Top level of the peak triplet filter and hash block.
//
// Usage: one candidate triple (anchor, older and newer peak) is written on the
// input side as a queue transfer: push while full is low. Each triple yields
// exactly one result, read on the output side as a queue: while empty is low
// the oldest result sits on the result ports and pop takes it.
// Configuration registers are written over cfg_valid/cfg_ready with cfg_index
// and cfg_data; cfg_ready is always high. Write them only while the block is
// idle.
// A triple passes the front stage, the middle queue, the divider stages and
// the result write. Throughput: one triple per cycle while full is low, set
// by the front difference stage, the four-entry middle queue and a divider
// that resolves the six time quotient bits two at a time over two pipeline
// stages and the result write, for both time differences in parallel.
// Reset clears all queues and restores the register defaults.
// When the receiver stalls, results collect in an eight-entry result queue;
// the back stops drawing from the middle queue once that is booked up, and
// full rises when the middle queue and the front stage are both occupied.
module peak_triplet_filter_hash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [15:0] anchor_freq,
	input  logic [31:0] anchor_time_ms,
	input  logic [15:0] anchor_level,
	input  logic [15:0] older_freq,
	input  logic [31:0] older_time_ms,
	input  logic [15:0] newer_freq,
	input  logic [31:0] newer_time_ms,
	output logic        empty,
	input  logic        pop,
	output logic        accepted,
	output logic [2:0]  reject_reason,
	output logic [31:0] hash,
	output logic [31:0] point_time_ms,
	output logic [15:0] point_freq,
	output logic [15:0] point_level,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import ptfh_pkg::*;

	logic [15:0] min_freq_delta_q, max_freq_delta_q, max_time_delta_q;
	logic [9:0]  quant_step_q;
	limits_t     limits;
	logic        mq_wr, mq_full, mq_rd, mq_empty;
	work_t       mq_wr_data, mq_rd_data;
	res_t        res;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_freq_delta_q <= RST_MIN_FREQ_DELTA;
			max_freq_delta_q <= RST_MAX_FREQ_DELTA;
			max_time_delta_q <= RST_MAX_TIME_DELTA;
			quant_step_q     <= RST_QUANT_STEP;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MIN_FREQ_DELTA: min_freq_delta_q <= cfg_data;
				REG_MAX_FREQ_DELTA: max_freq_delta_q <= cfg_data;
				REG_MAX_TIME_DELTA: max_time_delta_q <= cfg_data;
				REG_QUANT_STEP:     quant_step_q     <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	assign limits.fmin = min_freq_delta_q;
	assign limits.fmax = max_freq_delta_q;
	assign limits.tmax = max_time_delta_q;

	// Front: differences and filters
	ptfh_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.anchor_freq    (anchor_freq),
		.anchor_time_ms (anchor_time_ms),
		.anchor_level   (anchor_level),
		.older_freq     (older_freq),
		.older_time_ms  (older_time_ms),
		.newer_freq     (newer_freq),
		.newer_time_ms  (newer_time_ms),
		.limits         (limits),
		.q_wr           (mq_wr),
		.q_wr_data      (mq_wr_data),
		.q_full         (mq_full)
	);

	// Middle queue
	ptfh_mid_q u_mid_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (mq_wr),
		.wr_data (mq_wr_data),
		.q_full  (mq_full),
		.rd      (mq_rd),
		.rd_data (mq_rd_data),
		.q_empty (mq_empty)
	);

	// Back: time quantization, hash, result queue
	ptfh_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.quant_step (quant_step_q),
		.q_rd_data  (mq_rd_data),
		.q_empty    (mq_empty),
		.q_rd       (mq_rd),
		.empty      (empty),
		.pop        (pop),
		.res        (res)
	);

	assign accepted      = res.accepted;
	assign reject_reason = res.reason;
	assign hash          = res.hash;
	assign point_time_ms = res.ptime;
	assign point_freq    = res.pfreq;
	assign point_level   = res.plevel;

endmodule

FILE: src/ptfh_front.sv
// Front: takes triples, forms differences and applies the filters in order.
module ptfh_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [15:0]           anchor_freq,
	input  logic [31:0]           anchor_time_ms,
	input  logic [15:0]           anchor_level,
	input  logic [15:0]           older_freq,
	input  logic [31:0]           older_time_ms,
	input  logic [15:0]           newer_freq,
	input  logic [31:0]           newer_time_ms,
	input  ptfh_pkg::limits_t     limits,
	output logic                  q_wr,
	output ptfh_pkg::work_t       q_wr_data,
	input  logic                  q_full
);
	import ptfh_pkg::*;

	logic               valid_s1;
	logic signed [16:0] df1_s1, df2_s1;
	logic signed [32:0] dt1_s1, dt2_s1;
	logic [15:0]        af_s1, alev_s1;
	logic [31:0]        at_s1;

	logic        take;
	logic [15:0] adf1, adf2;
	logic [31:0] adt1, adt2;
	logic signed [17:0] ddf;
	logic [16:0] addf;
	logic [15:0] fmin_half;
	logic [2:0]  reason;
	logic        ok;

	// Stage holds while the queue is full
	assign q_wr = valid_s1 && !q_full;
	assign full = valid_s1 && q_full;
	assign take = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take || q_wr) begin
			valid_s1 <= take;
		end
	end

	// Raw differences
	always_ff @(posedge clk) begin
		if (take) begin
			df1_s1  <= $signed({1'b0, anchor_freq}) - $signed({1'b0, older_freq});
			df2_s1  <= $signed({1'b0, newer_freq}) - $signed({1'b0, anchor_freq});
			dt1_s1  <= $signed({1'b0, anchor_time_ms}) - $signed({1'b0, older_time_ms});
			dt2_s1  <= $signed({1'b0, newer_time_ms}) - $signed({1'b0, anchor_time_ms});
			af_s1   <= anchor_freq;
			at_s1   <= anchor_time_ms;
			alev_s1 <= anchor_level;
		end
	end

	// Magnitudes
	always_comb begin
		adf1      = df1_s1[16] ? 16'(-df1_s1) : df1_s1[15:0];
		adf2      = df2_s1[16] ? 16'(-df2_s1) : df2_s1[15:0];
		adt1      = dt1_s1[32] ? 32'(-dt1_s1) : dt1_s1[31:0];
		adt2      = dt2_s1[32] ? 32'(-dt2_s1) : dt2_s1[31:0];
		ddf       = 18'(df1_s1) - 18'(df2_s1);
		addf      = ddf[17] ? 17'(-ddf) : ddf[16:0];
		fmin_half = {1'b0, limits.fmin[15:1]};
	end

	// Filters, first failing one wins
	always_comb begin
		priority if (adf1 < limits.fmin) begin
			reason = RSN_DF1_SMALL;
		end else if (adf1 > limits.fmax) begin
			reason = RSN_DF1_LARGE;
		end else if (adt1 > {16'd0, limits.tmax}) begin
			reason = RSN_DT1_LARGE;
		end else if (adf2 < limits.fmin || adf2 > limits.fmax) begin
			reason = RSN_DF2_RANGE;
		end else if (adt2 > {16'd0, limits.tmax}) begin
			reason = RSN_DT2_LARGE;
		end else if (addf < {1'b0, fmin_half}) begin
			reason = RSN_SIMILAR;
		end else begin
			reason = RSN_OK;
		end
	end

	// Classified item; point fields zeroed on reject
	always_comb begin
		ok                = (reason == RSN_OK);
		q_wr_data.reason  = reason;
		q_wr_data.fcode1  = {df1_s1[16], adf1[9:1]};
		q_wr_data.fcode2  = {df2_s1[16], adf2[9:1]};
		q_wr_data.tmag1   = adt1[15:0];
		q_wr_data.tneg1   = dt1_s1[32];
		q_wr_data.tmag2   = adt2[15:0];
		q_wr_data.tneg2   = dt2_s1[32];
		q_wr_data.freq_hi = af_s1[11:0];
		q_wr_data.ptime   = ok ? at_s1 : 32'd0;
		q_wr_data.pfreq   = ok ? af_s1 : 16'd0;
		q_wr_data.plevel  = ok ? alev_s1 : 16'd0;
	end

endmodule

FILE: src/ptfh_mid_q.sv
// Short queue of classified items between the front and the back.
module ptfh_mid_q (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  ptfh_pkg::work_t wr_data,
	output logic            q_full,
	input  logic            rd,
	output ptfh_pkg::work_t rd_data,
	output logic            q_empty
);
	import ptfh_pkg::*;

	work_t             mem_q [MQ_DEPTH];
	logic [MQ_AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [MQ_AW:0]    count_q;

	assign q_full  = (count_q == (MQ_AW+1)'(MQ_DEPTH));
	assign q_empty = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (rd) rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + (MQ_AW+1)'(wr) - (MQ_AW+1)'(rd);
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (wr) mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

FILE: src/ptfh_back.sv
// Back: quantizes time differences, builds the hash and queues results.
module ptfh_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [9:0]      quant_step,
	input  ptfh_pkg::work_t q_rd_data,
	input  logic            q_empty,
	output logic            q_rd,
	output logic            empty,
	input  logic            pop,
	output ptfh_pkg::res_t  res
);
	import ptfh_pkg::*;

	logic [9:0] st;
	logic       v_s1, v_s2;
	work_t      item_s1, item_s2;
	div_lane_t  l1_s1, l2_s1, l1_s2, l2_s2;
	div_lane_t  l1_fin, l2_fin;
	res_t       res_new;
	logic       oq_wr, oq_rd;

	res_t              oq_mem_q [OQ_DEPTH];
	logic [OQ_AW-1:0]  oq_wr_ptr_q, oq_rd_ptr_q;
	logic [OQ_AW:0]    oq_cnt_q;
	logic [OQ_AW:0]    booked;

	// A step of zero counts as one
	assign st = (quant_step == 10'd0) ? 10'd1 : quant_step;

	// Issue only with room reserved in the result queue
	assign booked = oq_cnt_q + (OQ_AW+1)'(v_s1) + (OQ_AW+1)'(v_s2);
	assign q_rd   = !q_empty && (booked < (OQ_AW+1)'(OQ_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= q_rd;
			v_s2 <= v_s1;
		end
	end

	// Divider: saturation check and quotient bits 5..4, then 3..2
	always_ff @(posedge clk) begin
		item_s1 <= q_rd_data;
		l1_s1   <= div_steps(div_start(q_rd_data.tmag1, q_rd_data.tneg1, st), st, 5);
		l2_s1   <= div_steps(div_start(q_rd_data.tmag2, q_rd_data.tneg2, st), st, 5);
		item_s2 <= item_s1;
		l1_s2   <= div_steps(l1_s1, st, 3);
		l2_s2   <= div_steps(l2_s1, st, 3);
	end

	// Last quotient bits, time codes and hash
	always_comb begin
		l1_fin = div_steps(l1_s2, st, 1);
		l2_fin = div_steps(l2_s2, st, 1);
		res_new.accepted = (item_s2.reason == RSN_OK);
		res_new.reason   = item_s2.reason;
		res_new.hash     = res_new.accepted ?
			{item_s2.freq_hi, combo(item_s2.fcode1, time_code(l1_fin)),
			 combo(item_s2.fcode2, time_code(l2_fin))} : 32'd0;
		res_new.ptime    = item_s2.ptime;
		res_new.pfreq    = item_s2.pfreq;
		res_new.plevel   = item_s2.plevel;
	end

	// Result queue
	assign oq_wr = v_s2;
	assign empty = (oq_cnt_q == '0);
	assign oq_rd = pop && !empty;
	assign res   = oq_mem_q[oq_rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_ptr_q <= '0;
			oq_rd_ptr_q <= '0;
			oq_cnt_q    <= '0;
		end else begin
			if (oq_wr) oq_wr_ptr_q <= oq_wr_ptr_q + 1'b1;
			if (oq_rd) oq_rd_ptr_q <= oq_rd_ptr_q + 1'b1;
			oq_cnt_q <= oq_cnt_q + (OQ_AW+1)'(oq_wr) - (OQ_AW+1)'(oq_rd);
		end
	end

	always_ff @(posedge clk) begin
		if (oq_wr) oq_mem_q[oq_wr_ptr_q] <= res_new;
	end

endmodule

FILE: verif/tb.sv
// Self-checking bench for the peak triplet filter and hash block.
module tb;
	import ptfh_pkg::*;

	localparam int     HALF_PERIOD   = 5;
	localparam int     NUM_PHASES    = 10;
	localparam int     PHASE_TRIPLES = 175;
	localparam int     MAX_GAP       = 17;
	localparam int     HOLD_CYCLES   = 120;
	localparam int     SETTLE_CYCLES = 6;
	localparam int     IDLE_LIMIT    = 1000;
	localparam int     MAX_REPORTS   = 10;
	localparam longint TIME_TOP      = 64'h0000_0000_FFFF_FFFF;

	// One candidate triple of peaks
	typedef struct {
		logic [15:0] af;
		logic [31:0] at;
		logic [15:0] lvl;
		logic [15:0] of;
		logic [31:0] ot;
		logic [15:0] nf;
		logic [31:0] nt;
	} triple_t;

	typedef enum logic {ROW_TRIPLE, ROW_REG} row_kind_t;

	// Directed step: a triple (optionally with a typed-in reject reason) or a register write
	typedef struct {
		row_kind_t   kind;
		triple_t     trip;
		bit          typed;
		logic [2:0]  typed_reason;
		logic [1:0]  reg_index;
		logic [15:0] reg_data;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [15:0] anchor_freq = '0;
	logic [31:0] anchor_time_ms = '0;
	logic [15:0] anchor_level = '0;
	logic [15:0] older_freq = '0;
	logic [31:0] older_time_ms = '0;
	logic [15:0] newer_freq = '0;
	logic [31:0] newer_time_ms = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic        accepted;
	logic [2:0]  reject_reason;
	logic [31:0] hash;
	logic [31:0] point_time_ms;
	logic [15:0] point_freq;
	logic [15:0] point_level;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = REG_MIN_FREQ_DELTA;
	logic [15:0] cfg_data = '0;

	// Bench copy of the filter limits
	logic [15:0] lim_fmin = RST_MIN_FREQ_DELTA;
	logic [15:0] lim_fmax = RST_MAX_FREQ_DELTA;
	logic [15:0] lim_tmax = RST_MAX_TIME_DELTA;
	logic [9:0]  lim_step = RST_QUANT_STEP;

	res_t pending_hashes[$];
	row_t dir_rows[$];
	int   mismatches = 0;
	int   quiet_cycles = 0;
	bit   tx_burst = 1'b0;
	bit   rx_burst = 1'b0;
	bit   hold_req = 1'b0;

	peak_triplet_filter_hash dut (.*);

	always #HALF_PERIOD clk = ~clk;

	function automatic longint mag(longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic longint rand_sign(longint v);
		return $urandom_range(0, 1) ? -v : v;
	endfunction

	// Quantized time difference, truncated toward zero, saturated, offset to 0..63
	function automatic logic [5:0] quant_code(longint dt);
		longint st;
		longint q;
		st = (lim_step == 10'd0) ? 1 : longint'(lim_step);
		q = dt / st;
		if (q < -32) q = -32;
		if (q > 31) q = 31;
		return 6'(q + 32);
	endfunction

	// Halved frequency difference with sign bit, mixed with the time code
	function automatic logic [9:0] mix_code(longint df, longint dt);
		logic [9:0] m;
		logic [5:0] t;
		m = 10'(mag(df) / 2) & 10'h1FF;
		if (df < 0) m[9] = 1'b1;
		t = quant_code(dt);
		return m ^ (10'(t & 6'h03) << 8) ^ (10'(t & 6'h3C) << 2);
	endfunction

	// Expected result of one triple under the current limits
	function automatic res_t hash_triple(triple_t t);
		longint df1, df2, dt1, dt2, fmin, fmax, tmax;
		res_t r;
		df1 = longint'(t.af) - longint'(t.of);
		df2 = longint'(t.nf) - longint'(t.af);
		dt1 = longint'(t.at) - longint'(t.ot);
		dt2 = longint'(t.nt) - longint'(t.at);
		fmin = longint'(lim_fmin);
		fmax = longint'(lim_fmax);
		tmax = longint'(lim_tmax);
		r = '0;
		// filters in reason order, first failure wins
		if (mag(df1) < fmin) r.reason = RSN_DF1_SMALL;
		else if (mag(df1) > fmax) r.reason = RSN_DF1_LARGE;
		else if (mag(dt1) > tmax) r.reason = RSN_DT1_LARGE;
		else if (mag(df2) < fmin || mag(df2) > fmax) r.reason = RSN_DF2_RANGE;
		else if (mag(dt2) > tmax) r.reason = RSN_DT2_LARGE;
		else if (mag(df1 - df2) < fmin / 2) r.reason = RSN_SIMILAR;
		if (r.reason == RSN_OK) begin
			r.accepted = 1'b1;
			r.hash = {t.af[11:0], mix_code(df1, dt1), mix_code(df2, dt2)};
			r.ptime = t.at;
			r.pfreq = t.af;
			r.plevel = t.lvl;
		end
		return r;
	endfunction

	// Frequency difference magnitude: want 0 inside the limits, 1 below, 2 above
	function automatic longint pick_fdelta(int want);
		longint lo, hi;
		lo = lim_fmin;
		hi = lim_fmax;
		if (want == 1 && lim_fmin != 16'd0) begin
			lo = 0;
			hi = longint'(lim_fmin) - 1;
		end else if (want == 2 && lim_fmax != 16'hFFFF) begin
			lo = longint'(lim_fmax) + 1;
			hi = 65535;
		end
		if (lo > hi) return longint'($urandom_range(0, 65535));
		case ($urandom_range(0, 5))
			0: return lo;
			1: return hi;
			default: return lo + longint'($urandom_range(0, int'(hi - lo)));
		endcase
	endfunction

	// Time difference magnitude, inside the limit or just past it
	function automatic longint pick_tdelta(bit over);
		longint lim;
		lim = lim_tmax;
		if (over) return lim + 1 + longint'($urandom_range(0, 3000));
		case ($urandom_range(0, 5))
			0: return lim;
			1: return 0;
			default: return longint'($urandom_range(0, int'(lim)));
		endcase
	endfunction

	// base + d, or base - d when that would leave the 32-bit range
	function automatic logic [31:0] offset_time(logic [31:0] base, longint d);
		longint v;
		v = longint'(base) + d;
		if (v < 0 || v > TIME_TOP) v = longint'(base) - d;
		return v[31:0];
	endfunction

	// Random triple: mostly shaped to reach a chosen filter outcome, some pure noise
	function automatic triple_t make_triple();
		triple_t t;
		int aim, goal;
		longint d1, d2, lo, hi, half;
		t.af = 16'($urandom);
		t.at = $urandom;
		t.lvl = 16'($urandom);
		t.of = 16'($urandom);
		t.ot = $urandom;
		t.nf = 16'($urandom);
		t.nt = $urandom;
		aim = $urandom_range(0, 99);
		if (aim < 10) return t;
		goal = (aim < 60) ? 0 : (aim < 66) ? 1 : (aim < 72) ? 2 : (aim < 78) ? 3 :
			(aim < 86) ? 4 : (aim < 92) ? 5 : 6;
		d1 = rand_sign(pick_fdelta((goal == 1 || goal == 2) ? goal : 0));
		d2 = rand_sign(pick_fdelta((goal == 4) ? $urandom_range(1, 2) : 0));
		half = longint'(lim_fmin >> 1);
		if (goal == 6 && half > 0) d2 = d1 + rand_sign(longint'($urandom_range(0, int'(half - 1))));
		// anchor frequency that keeps both partners in range
		lo = 0;
		if (d1 > lo) lo = d1;
		if (-d2 > lo) lo = -d2;
		hi = 65535;
		if (65535 + d1 < hi) hi = 65535 + d1;
		if (65535 - d2 < hi) hi = 65535 - d2;
		if (lo <= hi) begin
			t.af = 16'(lo + longint'($urandom_range(0, int'(hi - lo))));
			t.of = 16'(longint'(t.af) - d1);
			t.nf = 16'(longint'(t.af) + d2);
		end
		// anchor time now and then right at either end of the range
		if ($urandom_range(0, 15) == 0)
			t.at = $urandom_range(0, 1) ? 32'hFFFF_FFFF - $urandom_range(0, 500)
				: $urandom_range(0, 500);
		t.ot = offset_time(t.at, rand_sign(pick_tdelta(goal == 3)));
		t.nt = offset_time(t.at, rand_sign(pick_tdelta(goal == 5)));
		return t;
	endfunction

	function automatic void add_trip(logic [15:0] af, logic [31:0] at, logic [15:0] lvl,
			logic [15:0] of, logic [31:0] ot, logic [15:0] nf, logic [31:0] nt,
			bit typed = 1'b0, logic [2:0] rsn = RSN_OK);
		row_t r;
		r.kind = ROW_TRIPLE;
		r.trip.af = af;
		r.trip.at = at;
		r.trip.lvl = lvl;
		r.trip.of = of;
		r.trip.ot = ot;
		r.trip.nf = nf;
		r.trip.nt = nt;
		r.typed = typed;
		r.typed_reason = rsn;
		r.reg_index = REG_MIN_FREQ_DELTA;
		r.reg_data = '0;
		dir_rows = {dir_rows, r};
	endfunction

	function automatic void add_reg(logic [1:0] idx, logic [15:0] data);
		row_t r;
		r.kind = ROW_REG;
		r.trip = '{default: '0};
		r.typed = 1'b0;
		r.typed_reason = RSN_OK;
		r.reg_index = idx;
		r.reg_data = data;
		dir_rows = {dir_rows, r};
	endfunction

	function automatic int draw_gap(bit burst);
		return burst ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	// Offer one triple and book its expected result at the transfer
	task automatic send_triple(triple_t t, bit typed, logic [2:0] typed_reason);
		int gap;
		res_t r;
		gap = draw_gap(tx_burst);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		anchor_freq <= t.af;
		anchor_time_ms <= t.at;
		anchor_level <= t.lvl;
		older_freq <= t.of;
		older_time_ms <= t.ot;
		newer_freq <= t.nf;
		newer_time_ms <= t.nt;
		do @(posedge clk); while (full);
		if (typed) begin
			r = '0;
			r.reason = typed_reason;
		end else begin
			r = hash_triple(t);
		end
		pending_hashes = {pending_hashes, r};
	endtask

	// Stop offering and wait until every booked result has come out
	task automatic drain();
		push <= 1'b0;
		while (pending_hashes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register write; cfg_valid stays high so writes can go back to back
	task automatic write_reg(logic [1:0] idx, logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_MIN_FREQ_DELTA: lim_fmin = data;
			REG_MAX_FREQ_DELTA: lim_fmax = data;
			REG_MAX_TIME_DELTA: lim_tmax = data;
			REG_QUANT_STEP:     lim_step = data[9:0];
			default: ;
		endcase
	endtask

	// New limits for a random phase, extremes included
	task automatic random_limits();
		logic [15:0] v;
		case ($urandom_range(0, 9))
			0: v = 16'd0;
			1: v = 16'($urandom);
			default: v = 16'($urandom_range(0, 120));
		endcase
		write_reg(REG_MIN_FREQ_DELTA, v);
		case ($urandom_range(0, 9))
			0: v = 16'hFFFF;
			1: v = 16'($urandom_range(0, 60));
			default: v = 16'($urandom_range(150, 3000));
		endcase
		write_reg(REG_MAX_FREQ_DELTA, v);
		case ($urandom_range(0, 9))
			0: v = 16'd0;
			1: v = 16'hFFFF;
			default: v = 16'($urandom_range(20, 2000));
		endcase
		write_reg(REG_MAX_TIME_DELTA, v);
		case ($urandom_range(0, 9))
			0: v = 16'd0;
			1: v = 16'd1;
			2: v = 16'd1000;
			3: v = 16'd1023;
			default: v = 16'($urandom_range(2, 300));
		endcase
		// bits above the step width are ignored by the block
		v[15:10] = 6'($urandom);
		write_reg(REG_QUANT_STEP, v);
		cfg_valid <= 1'b0;
	endtask

	// No transfer of any kind for too long ends the run
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	// Result side: random pops, one long hold-off on request, check against the oldest booking
	initial begin : result_side
		int gap;
		res_t want, got;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				gap = HOLD_CYCLES;
				hold_req = 1'b0;
			end else begin
				gap = draw_gap(rx_burst);
			end
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			got = {accepted, reject_reason, hash, point_time_ms, point_freq, point_level};
			if (pending_hashes.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("tb: result with nothing pending: acc=%0b rsn=%0d hash=%h",
						got.accepted, got.reason, got.hash);
			end else begin
				want = pending_hashes.pop_front();
				if (got.accepted !== want.accepted || got.reason !== want.reason ||
						got.hash !== want.hash || got.ptime !== want.ptime ||
						got.pfreq !== want.pfreq || got.plevel !== want.plevel) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("tb: mismatch want acc=%0b rsn=%0d hash=%h time=%h freq=%h lvl=%h",
							want.accepted, want.reason, want.hash, want.ptime, want.pfreq,
							want.plevel);
						$display("tb:          got  acc=%0b rsn=%0d hash=%h time=%h freq=%h lvl=%h",
							got.accepted, got.reason, got.hash, got.ptime, got.pfreq,
							got.plevel);
					end
				end
			end
		end
	end

	// Input side: reset, directed steps, then random phases
	initial begin : stimulus
		row_t row;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset limits: one triple per reject reason, an accept, edges of the ranges
		add_trip(16'd1000, 32'd1000, 16'h1234, 16'd1000, 32'd900, 16'd1100, 32'd1100,
			1'b1, RSN_DF1_SMALL);
		add_trip(16'd1000, 32'd1000, 16'h1234, 16'd0, 32'd900, 16'd1100, 32'd1100,
			1'b1, RSN_DF1_LARGE);
		add_trip(16'd1000, 32'd5000, 16'h1234, 16'd900, 32'd0, 16'd1100, 32'd5100,
			1'b1, RSN_DT1_LARGE);
		add_trip(16'd1000, 32'd1000, 16'h1234, 16'd900, 32'd900, 16'd1000, 32'd1100,
			1'b1, RSN_DF2_RANGE);
		add_trip(16'd1000, 32'd1000, 16'h1234, 16'd900, 32'd900, 16'd1100, 32'd5000,
			1'b1, RSN_DT2_LARGE);
		add_trip(16'd1000, 32'd1000, 16'h1234, 16'd900, 32'd900, 16'd1100, 32'd1100,
			1'b1, RSN_SIMILAR);
		add_trip(16'd1000, 32'd1000, 16'hA5A5, 16'd900, 32'd900, 16'd800, 32'd1100);
		// differences exactly on the limits
		add_trip(16'd1000, 32'd1000, 16'h5A5A, 16'd700, 32'd700, 16'd1030, 32'd1300);
		// all-ones anchor
		add_trip(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFF9B, 32'hFFFF_FF05, 16'hFF05,
			32'hFFFF_FFFF);
		add_trip(16'd0, 32'd0, 16'd0, 16'd0, 32'd0, 16'd0, 32'd0, 1'b1, RSN_DF1_SMALL);
		// both differences negative
		add_trip(16'd2000, 32'd1000, 16'h0F0F, 16'd2299, 32'd1290, 16'd1800, 32'd710);
		// older timestamp far ahead of the anchor, no wraparound
		add_trip(16'd1000, 32'd0, 16'h1234, 16'd900, 32'hFFFF_FFFF, 16'd1100, 32'd100,
			1'b1, RSN_DT1_LARGE);
		// anchor frequency bits above 11 drop out of the hash
		add_trip(16'hF123, 32'd12345, 16'h8001, 16'hF0F1, 32'd12336, 16'hF1EB, 32'd12354);

		// widest limits and a zero step, which counts as one
		add_reg(REG_MIN_FREQ_DELTA, 16'd0);
		add_reg(REG_MAX_FREQ_DELTA, 16'hFFFF);
		add_reg(REG_MAX_TIME_DELTA, 16'hFFFF);
		add_reg(REG_QUANT_STEP, 16'd0);
		add_trip(16'd30000, 32'd100000, 16'h7FFF, 16'd0, 32'd34465, 16'd65535, 32'd165535);
		add_trip(16'd500, 32'd7, 16'h0001, 16'd500, 32'd7, 16'd500, 32'd7);
		add_trip(16'd100, 32'd70000, 16'h4000, 16'd200, 32'd135535, 16'd0, 32'd4465);

		// minimum above maximum: nothing passes the frequency tests
		add_reg(REG_QUANT_STEP, 16'hFFFF);
		add_reg(REG_MIN_FREQ_DELTA, 16'd500);
		add_reg(REG_MAX_FREQ_DELTA, 16'd100);
		add_trip(16'd1000, 32'd0, 16'h2222, 16'd800, 32'd0, 16'd1000, 32'd0,
			1'b1, RSN_DF1_SMALL);
		add_trip(16'd1000, 32'd0, 16'h2222, 16'd0, 32'd0, 16'd1000, 32'd0,
			1'b1, RSN_DF1_LARGE);

		// only full-scale frequency jumps with zero time difference pass
		add_reg(REG_MIN_FREQ_DELTA, 16'hFFFF);
		add_reg(REG_MAX_FREQ_DELTA, 16'hFFFF);
		add_reg(REG_MAX_TIME_DELTA, 16'd0);
		add_reg(REG_QUANT_STEP, 16'd1000);
		add_trip(16'hFFFF, 32'd5, 16'h3333, 16'd0, 32'd5, 16'd0, 32'd5);
		add_trip(16'hFFFF, 32'd5, 16'h3333, 16'd0, 32'd4, 16'd0, 32'd5,
			1'b1, RSN_DT1_LARGE);
		add_trip(16'hFFFF, 32'd5, 16'h3333, 16'd0, 32'd5, 16'd0, 32'd6,
			1'b1, RSN_DT2_LARGE);

		for (int i = 0; i < dir_rows.size(); i++) begin
			row = dir_rows[i];
			if (row.kind == ROW_REG) begin
				if (i > 0 && dir_rows[i-1].kind == ROW_TRIPLE) drain();
				write_reg(row.reg_index, row.reg_data);
				if (i + 1 == dir_rows.size() || dir_rows[i+1].kind != ROW_REG)
					cfg_valid <= 1'b0;
			end else begin
				send_triple(row.trip, row.typed, row.typed_reason);
			end
		end

		// random phases, each under fresh limits; the first one overfills the block
		for (int p = 0; p < NUM_PHASES; p++) begin
			drain();
			random_limits();
			tx_burst = (p % 3 == 0);
			rx_burst = (p % 4 == 1);
			if (p == 0) hold_req = 1'b1;
			for (int k = 0; k < PHASE_TRIPLES; k++) begin
				if (p % 2 == 1 && k == PHASE_TRIPLES / 2) drain();
				send_triple(make_triple(), 1'b0, RSN_OK);
			end
		end
		drain();

		if (mismatches == 0 && pending_hashes.size() == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
